[design/lmsc_pkg.sv]
// Shared types, codes and schedule tables of the LIN master schedule controller.
`default_nettype none
package lmsc_pkg;

  localparam int unsigned PARAM_INDEX_BITS_DEF = 8;
  localparam logic [7:0]  HOLD_CYCLES_RESET    = 8'd20;

  localparam int unsigned SLOT_BITS = 4;
  localparam int unsigned SLOTS     = 1 << SLOT_BITS;

  // func codes
  localparam logic [2:0] FUNC_TICK     = 3'd0;
  localparam logic [2:0] FUNC_POST     = 3'd1;
  localparam logic [2:0] FUNC_HEADER   = 3'd2;
  localparam logic [2:0] FUNC_RESPONSE = 3'd3;
  localparam logic [2:0] FUNC_ABANDON  = 3'd4;

  // frame kinds
  localparam logic [2:0] FK_RELAYS     = 3'd0;
  localparam logic [2:0] FK_CFG_REQ    = 3'd1;
  localparam logic [2:0] FK_CFG_RESP   = 3'd2;
  localparam logic [2:0] FK_MASTER_REQ = 3'd3;
  localparam logic [2:0] FK_SLAVE_RESP = 3'd4;
  localparam logic [2:0] FK_END        = 3'd7;

  // config flavours
  localparam logic [1:0] FLAV_NOP = 2'd0;
  localparam logic [1:0] FLAV_GET = 2'd1;
  localparam logic [1:0] FLAV_SET = 2'd2;

  // result actions
  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_HEADER    = 3'd1;
  localparam logic [2:0] ACT_RELAY     = 3'd2;
  localparam logic [2:0] ACT_LISTEN    = 3'd3;
  localparam logic [2:0] ACT_SEND_REQ  = 3'd4;
  localparam logic [2:0] ACT_CFG_REPLY = 3'd5;
  localparam logic [2:0] ACT_WRITE_PRM = 3'd6;
  localparam logic [2:0] ACT_CAPTURED  = 3'd7;

  // register indexes
  localparam logic REG_HOLD_CYCLES = 1'b0;

  localparam logic [2:0] NormalTable [SLOTS] = '{
    FK_RELAYS, FK_RELAYS, FK_RELAYS, FK_RELAYS, FK_CFG_REQ,
    FK_RELAYS, FK_RELAYS, FK_RELAYS, FK_RELAYS,
    FK_MASTER_REQ, FK_SLAVE_RESP, FK_END,
    FK_END, FK_END, FK_END, FK_END
  };

  localparam logic [2:0] ConfigTable [SLOTS] = '{
    FK_RELAYS, FK_CFG_REQ, FK_CFG_RESP, FK_RELAYS, FK_CFG_REQ, FK_CFG_RESP,
    FK_MASTER_REQ, FK_CFG_REQ, FK_CFG_RESP, FK_SLAVE_RESP, FK_CFG_REQ,
    FK_CFG_RESP, FK_END,
    FK_END, FK_END, FK_END
  };

  typedef struct packed {
    logic exec;
    logic step;
  } lmsc_cmd_t;

  typedef struct packed {
    logic in_is_tick;
    logic hit;
  } lmsc_sts_t;

  function automatic logic [2:0] lmsc_slot_kind(input logic use_cfg,
                                                input logic [SLOT_BITS-1:0] idx);
    logic [2:0] fk;
    if (use_cfg) begin
      fk = ConfigTable[idx];
    end else begin
      fk = NormalTable[idx];
    end
    return fk;
  endfunction

endpackage
`default_nettype wire

[design/lmsc_ctrl.sv]
// Controller state machine: accept, schedule scan and result hand-off.
`default_nettype none
module lmsc_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  input  wire lmsc_pkg::lmsc_sts_t sts_i,
  output lmsc_pkg::lmsc_cmd_t      cmd_o
);
  import lmsc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_OUT  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign accept      = in_valid_i && in_ready_o;

  always_comb begin
    state_d    = state_q;
    cmd_o.exec = 1'b0;
    cmd_o.step = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (sts_i.in_is_tick) begin
            state_d = S_SCAN;
          end else begin
            cmd_o.exec = 1'b1;
            state_d    = S_OUT;
          end
        end
      end
      S_SCAN: begin
        cmd_o.step = 1'b1;
        if (sts_i.hit) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

`ifndef ASSERT_OFF
  a_hit_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN && sts_i.hit) |=> (state_q == S_OUT))
    else $error("scan hit did not present a result");
  a_exec_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !sts_i.in_is_tick) |=> (state_q == S_OUT))
    else $error("non-tick item did not present a result");
  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && !in_ready_o))
    else $error("stalled result dropped");
`endif

endmodule
`default_nettype wire

[design/lmsc_dp.sv]
// Datapath: scheduler state, slot lookup, event decode and result register.
`default_nettype none
module lmsc_dp #(
  parameter int unsigned PARAM_INDEX_BITS = lmsc_pkg::PARAM_INDEX_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire lmsc_pkg::lmsc_cmd_t cmd_i,
  output lmsc_pkg::lmsc_sts_t      sts_o,
  input  wire logic [7:0]          hold_cycles_i,
  input  wire logic [2:0]          in_func_i,
  input  wire logic [15:0]         in_data_i,
  output logic [2:0]               out_action_o,
  output logic [15:0]              out_data_o
);
  import lmsc_pkg::*;

  localparam logic [7:0] ParamMask = (PARAM_INDEX_BITS >= 8) ? 8'hFF :
                                     8'((1 << PARAM_INDEX_BITS) - 1);

  logic [SLOT_BITS-1:0] slot_q;
  logic [7:0]           hold_q, hold_d;
  logic                 req_q, req_d;
  logic                 resp_q, resp_d;
  logic                 cfg_want_q, cfg_want_d;
  logic                 reply_q, reply_d;
  logic [7:0]           saved_q, saved_d;

  logic [2:0] act_q, act_d;
  logic [2:0] hdr_q;
  logic [7:0] pout_q, pout_d;
  logic       busy_q;

  logic       want;
  logic [2:0] kind;
  logic [1:0] flav;
  logic       to_master;
  logic [7:0] pin;

  logic [2:0] fk;
  logic       is_end, skip;

  assign want      = in_data_i[0];
  assign kind      = in_data_i[3:1];
  assign flav      = in_data_i[5:4];
  assign to_master = in_data_i[6];
  assign pin       = in_data_i[14:7] & ParamMask;

  assign fk     = lmsc_slot_kind(hold_q != 8'd0, slot_q);
  assign is_end = (fk == FK_END);
  assign skip   = (fk == FK_CFG_RESP && !cfg_want_q) ||
                  (fk == FK_MASTER_REQ && !req_q) ||
                  (fk == FK_SLAVE_RESP && !resp_q);

  assign sts_o.in_is_tick = (in_func_i == FUNC_TICK);
  assign sts_o.hit        = !is_end && !skip;

  always_comb begin
    hold_d     = hold_q;
    req_d      = req_q;
    resp_d     = resp_q;
    cfg_want_d = cfg_want_q;
    reply_d    = reply_q;
    saved_d    = saved_q;
    act_d      = ACT_NONE;
    pout_d     = 8'd0;
    case (in_func_i)
      FUNC_POST: begin
        req_d  = 1'b1;
        resp_d = want;
      end
      FUNC_HEADER: begin
        case (kind)
          FK_RELAYS: act_d = ACT_RELAY;
          FK_CFG_REQ, FK_SLAVE_RESP: act_d = ACT_LISTEN;
          FK_CFG_RESP: begin
            if (reply_q) begin
              reply_d = 1'b0;
              act_d   = ACT_CFG_REPLY;
              pout_d  = saved_q;
            end
          end
          FK_MASTER_REQ: begin
            if (req_q) begin
              req_d = 1'b0;
              act_d = ACT_SEND_REQ;
            end
          end
          default: act_d = ACT_NONE;
        endcase
      end
      FUNC_RESPONSE: begin
        case (kind)
          FK_CFG_REQ: begin
            hold_d = hold_cycles_i;
            if (flav != FLAV_NOP) begin
              cfg_want_d = 1'b1;
              if (to_master) begin
                if (flav == FLAV_GET) begin
                  saved_d = pin;
                  reply_d = 1'b1;
                end else if (flav == FLAV_SET) begin
                  act_d  = ACT_WRITE_PRM;
                  pout_d = pin;
                end
              end
            end
          end
          FK_SLAVE_RESP: begin
            if (resp_q) begin
              resp_d = 1'b0;
              act_d  = ACT_CAPTURED;
            end
          end
          default: act_d = ACT_NONE;
        endcase
      end
      FUNC_ABANDON: begin
        req_d  = 1'b0;
        resp_d = 1'b0;
      end
      default: act_d = ACT_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q     <= '0;
      hold_q     <= 8'd0;
      req_q      <= 1'b0;
      resp_q     <= 1'b0;
      cfg_want_q <= 1'b0;
      reply_q    <= 1'b0;
      saved_q    <= 8'd0;
    end else if (cmd_i.exec) begin
      hold_q     <= hold_d;
      req_q      <= req_d;
      resp_q     <= resp_d;
      cfg_want_q <= cfg_want_d;
      reply_q    <= reply_d;
      saved_q    <= saved_d;
    end else if (cmd_i.step) begin
      if (is_end) begin
        slot_q <= '0;
        if (hold_q != 8'd0) begin
          hold_q <= hold_q - 8'd1;
        end
      end else begin
        slot_q <= slot_q + SLOT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      act_q  <= act_d;
      hdr_q  <= 3'd0;
      pout_q <= pout_d;
      busy_q <= req_d || resp_d;
    end else if (cmd_i.step && sts_o.hit) begin
      act_q  <= ACT_HEADER;
      hdr_q  <= fk;
      pout_q <= 8'd0;
      busy_q <= req_q || resp_q;
    end
  end

  assign out_action_o = act_q;
  assign out_data_o   = {4'd0, busy_q, pout_q, hdr_q};

endmodule
`default_nettype wire

[design/lin_master_schedule_controller_top.sv]
// Top level of the LIN master schedule controller: stream ports and APB register.
//
// Input stream (s_axis): one item per bus event. tuser carries func (tick,
// post request, header seen, response received, abandon); tdata carries the
// frame fields. Output stream (m_axis): exactly one result item per input
// item, in order; tuser carries the action, tdata the header kind, parameter
// index and request-busy flag.
// One item is in the block at a time. A non-tick item yields its result in the
// cycle after acceptance. A tick walks the schedule table one slot per cycle
// until a slot with work is found (at most four slots), and its result is
// registered when that slot is found; the next item is taken the cycle after
// the result is taken.
// A stalled result is held on m_axis until m_axis_tready is high; no input is
// accepted meanwhile.
// APB: register 0 (address 0) is config_hold_cycles, reset value 20. Write
// only while the block is idle. pready is always high.
// Reset (rst_ni low, asynchronous) clears the slot index, hold counter and all
// pending flags; the block then waits for an input item.
`default_nettype none
module lin_master_schedule_controller_top #(
  parameter int unsigned PARAM_INDEX_BITS = lmsc_pkg::PARAM_INDEX_BITS_DEF
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // want_response[0], frame_kind[3:1], flavour[5:4], for_master[6],
  // param_in[14:7], zero[15]
  input  wire logic [15:0] s_axis_tdata,
  // func[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // header_kind[2:0], param_out[10:3], request_busy[11], zero[15:12]
  output logic [15:0]      m_axis_tdata,
  // action[2:0]
  output logic [2:0]       m_axis_tuser,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import lmsc_pkg::*;

  lmsc_cmd_t  cmd;
  lmsc_sts_t  sts;
  logic [7:0] hold_cycles_q;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_cycles_q <= HOLD_CYCLES_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_HOLD_CYCLES)) begin
      hold_cycles_q <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_HOLD_CYCLES) ? {24'd0, hold_cycles_q} : 32'd0;

  lmsc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  lmsc_dp #(
    .PARAM_INDEX_BITS (PARAM_INDEX_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .hold_cycles_i (hold_cycles_q),
    .in_func_i     (s_axis_tuser),
    .in_data_i     (s_axis_tdata),
    .out_action_o  (m_axis_tuser),
    .out_data_o    (m_axis_tdata)
  );

endmodule
`default_nettype wire
